// ----- rtl/tcam_pkg.sv -----
// Shared types, constants and helpers of the triggered CSMA-ALOHA MAC.
// Depends on nothing; the testbench imports it, and the RTL files but tcam_pkt_ram use scoped names.
package tcam_pkg;

  // Packet queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int QDEPTH_W    = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int MODE_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int LEN_W    = 12;
  localparam int TXLEN_W  = 13;
  localparam int ADDR_W   = 8;
  localparam int DRAW_W   = 16;
  localparam int TICKS_W  = 16;
  localparam int LISTEN_W = 17;
  localparam int DROP_W   = 2;
  localparam int NSTATE_W = 3;
  localparam int COUNT_W  = 5;
  localparam int QLIM_W   = 5;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 16;
  localparam int ENTRY_W  = HANDLE_W + LEN_W;

  // Event codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 3'd0,
    MODE_SUBMIT   = 3'd1,
    MODE_RX_START = 3'd2,
    MODE_RX_END   = 3'd3,
    MODE_TX_END   = 3'd4
  } mode_e;

  // Drop codes
  typedef enum logic [DROP_W-1:0] {
    DROP_NONE    = 2'd0,
    DROP_FULL    = 2'd1,
    DROP_CORRUPT = 2'd2
  } drop_e;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_NODE_ADDR     = 3'd0,
    REG_BCAST_ADDR    = 3'd1,
    REG_HEADER_BYTES  = 3'd2,
    REG_QUEUE_LIMIT   = 3'd3,
    REG_LISTEN_WINDOW = 3'd4,
    REG_LISTEN_BASE   = 3'd5,
    REG_TX_WINDOW     = 3'd6
  } cfg_reg_e;

  // Node state, one-hot
  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_LISTEN    = 5'b00010,
    ST_RX_IDLE   = 5'b00100,
    ST_RX_LISTEN = 5'b01000,
    ST_TX        = 5'b10000
  } ctrl_state_e;

  // Backoff phase, one-hot
  typedef enum logic [2:0] {
    PH_STOPPED = 3'b001,
    PH_RUNNING = 3'b010,
    PH_EXPIRED = 3'b100
  } phase_e;

  // Reported node state codes
  localparam logic [NSTATE_W-1:0] NS_IDLE      = 3'd0;
  localparam logic [NSTATE_W-1:0] NS_LISTEN    = 3'd1;
  localparam logic [NSTATE_W-1:0] NS_RX_IDLE   = 3'd2;
  localparam logic [NSTATE_W-1:0] NS_RX_LISTEN = 3'd3;
  localparam logic [NSTATE_W-1:0] NS_TX        = 3'd4;

  // One accepted input event
  typedef struct packed {
    mode_e               mode;
    logic [HANDLE_W-1:0] pkt_handle;
    logic [LEN_W-1:0]    pkt_length;
    logic                rx_error;
    logic [ADDR_W-1:0]   rx_dest_addr;
    logic                rx_is_trigger;
    logic [DRAW_W-1:0]   random_draw;
  } in_item_t;

  // Configuration write
  typedef struct packed {
    logic               we;
    logic [CIDX_W-1:0]  idx;
    logic [CDATA_W-1:0] data;
  } cfg_wr_t;

  // Control part of a result, known when the event is accepted
  typedef struct packed {
    logic                tx_start;
    drop_e               drop_code;
    logic [NSTATE_W-1:0] node_state;
    logic                tx_permitted;
    logic [COUNT_W-1:0]  queue_count;
  } rsp_info_t;

  // Queue memory write request
  typedef struct packed {
    logic                we;
    logic [QDEPTH_W-1:0] addr;
    logic [ENTRY_W-1:0]  data;
  } ram_wr_t;

  // Complete result
  typedef struct packed {
    logic                tx_start;
    logic [HANDLE_W-1:0] tx_handle;
    logic [TXLEN_W-1:0]  tx_length;
    drop_e               drop_code;
    logic [NSTATE_W-1:0] node_state;
    logic                tx_permitted;
    logic [COUNT_W-1:0]  queue_count;
  } out_item_t;

  // Advance a queue pointer with wrap at the queue depth
  function automatic logic [QDEPTH_W-1:0] next_ptr(input logic [QDEPTH_W-1:0] p);
    logic [QDEPTH_W-1:0] n;
    n = (p == QDEPTH_W'(QUEUE_DEPTH - 1)) ? '0 : p + QDEPTH_W'(1);
    return n;
  endfunction

  // Map the one-hot state onto its reported code
  function automatic logic [NSTATE_W-1:0] state_code(input ctrl_state_e s);
    logic [NSTATE_W-1:0] c;
    case (s)
      ST_IDLE:      c = NS_IDLE;
      ST_LISTEN:    c = NS_LISTEN;
      ST_RX_IDLE:   c = NS_RX_IDLE;
      ST_RX_LISTEN: c = NS_RX_LISTEN;
      ST_TX:        c = NS_TX;
      default:      c = NS_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/tcam_if.sv -----
// Valid/ready channel interfaces of the triggered CSMA-ALOHA MAC:
// event input, result output and configuration write. Uses tcam_pkg.
interface tcam_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcam_pkg::MODE_W-1:0]   mode;
  logic [tcam_pkg::HANDLE_W-1:0] pkt_handle;
  logic [tcam_pkg::LEN_W-1:0]    pkt_length;
  logic                          rx_error;
  logic [tcam_pkg::ADDR_W-1:0]   rx_dest_addr;
  logic                          rx_is_trigger;
  logic [tcam_pkg::DRAW_W-1:0]   random_draw;

  modport source (output valid, mode, pkt_handle, pkt_length, rx_error, rx_dest_addr,
                  rx_is_trigger, random_draw, input ready);
  modport sink (input valid, mode, pkt_handle, pkt_length, rx_error, rx_dest_addr,
                rx_is_trigger, random_draw, output ready);
endinterface

interface tcam_out_if;
  logic                          valid;
  logic                          ready;
  logic                          tx_start;
  logic [tcam_pkg::HANDLE_W-1:0] tx_handle;
  logic [tcam_pkg::TXLEN_W-1:0]  tx_length;
  logic [tcam_pkg::DROP_W-1:0]   drop_code;
  logic [tcam_pkg::NSTATE_W-1:0] node_state;
  logic                          tx_permitted;
  logic [tcam_pkg::COUNT_W-1:0]  queue_count;

  modport source (output valid, tx_start, tx_handle, tx_length, drop_code, node_state,
                  tx_permitted, queue_count, input ready);
  modport sink (input valid, tx_start, tx_handle, tx_length, drop_code, node_state,
                tx_permitted, queue_count, output ready);
endinterface

interface tcam_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tcam_pkg::CIDX_W-1:0]  index;
  logic [tcam_pkg::CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/triggered_csma_aloha_mac_top.sv -----
// Top level of the triggered CSMA-ALOHA MAC, node side.
// Depends on tcam_pkg, tcam_if, tcam_pkt_ram, tcam_ctrl and tcam_resp.
//
// Usage:
//   in_i  carries one MAC event per transfer: tick, packet submit, rx start,
//         rx end (with error, destination and trigger flags) or tx end.
//   out_o returns exactly one result per event: tx start with descriptor and
//         length, drop code, node state, window flag and queue count.
//   cfg_i writes one of the seven configuration registers per transfer; it is
//         always ready and is meant to be used while no event is in flight.
// Timing:
//   An event is accepted in every cycle the pipeline can move. The accepting
//   edge also registers the queue RAM read of the head descriptor into the
//   read stage; the output register loads from the read stage once it is free
//   or being taken, and out_o.valid rises as it loads.
//   Sustained throughput is one event per cycle while out_o.ready stays high.
// Reset:
//   rst_ni clears node state, counters, queue pointers and configuration to
//   their defaults; queue RAM contents are not cleared and need no sweep.
// Stalls:
//   With out_o.ready low the output register holds its result; one more event
//   may be accepted into the read stage, after which in_i.ready drops.
module triggered_csma_aloha_mac_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  tcam_in_if.sink    in_i,
  tcam_out_if.source out_o,
  tcam_cfg_if.sink   cfg_i
);

  tcam_pkg::in_item_t            item;
  tcam_pkg::cfg_wr_t             cfg_wr;
  tcam_pkg::ram_wr_t             ram_wr;
  tcam_pkg::rsp_info_t           info;
  tcam_pkg::out_item_t           res;
  logic [tcam_pkg::QDEPTH_W-1:0] ram_raddr;
  logic [tcam_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [tcam_pkg::ADDR_W-1:0]   hdr;
  logic                          in_ready;
  logic                          in_acc;

  // Unpack the channels
  always_comb begin
    item.mode          = tcam_pkg::mode_e'(in_i.mode);
    item.pkt_handle    = in_i.pkt_handle;
    item.pkt_length    = in_i.pkt_length;
    item.rx_error      = in_i.rx_error;
    item.rx_dest_addr  = in_i.rx_dest_addr;
    item.rx_is_trigger = in_i.rx_is_trigger;
    item.random_draw   = in_i.random_draw;
    cfg_wr.we          = cfg_i.valid;
    cfg_wr.idx         = cfg_i.index;
    cfg_wr.data        = cfg_i.data;
  end

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign in_acc      = in_i.valid && in_ready;

  tcam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .item_i      (item),
    .cfg_i       (cfg_wr),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .info_o      (info),
    .hdr_o       (hdr)
  );

  tcam_pkt_ram #(
    .DEPTH (tcam_pkg::QUEUE_DEPTH),
    .WIDTH (tcam_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (in_acc),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcam_resp u_resp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .info_i      (info),
    .rdata_i     (ram_rdata),
    .hdr_i       (hdr),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  // Pack the result channel
  always_comb begin
    out_o.tx_start     = res.tx_start;
    out_o.tx_handle    = res.tx_handle;
    out_o.tx_length    = res.tx_length;
    out_o.drop_code    = res.drop_code;
    out_o.node_state   = res.node_state;
    out_o.tx_permitted = res.tx_permitted;
    out_o.queue_count  = res.queue_count;
  end

endmodule

// ----- rtl/tcam_pkt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the queued packet descriptors; no dependencies.
module tcam_pkt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 28
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered when re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tcam_ctrl.sv -----
// MAC controller: configuration registers, node state, backoff and window
// counters, queue pointers. Drives the queue RAM write and read address. Uses tcam_pkg.
module tcam_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  tcam_pkg::in_item_t            item_i,
  input  tcam_pkg::cfg_wr_t             cfg_i,
  output tcam_pkg::ram_wr_t             ram_wr_o,
  output logic [tcam_pkg::QDEPTH_W-1:0] ram_raddr_o,
  output tcam_pkg::rsp_info_t           info_o,
  output logic [tcam_pkg::ADDR_W-1:0]   hdr_o
);

  // Configuration registers
  logic [tcam_pkg::ADDR_W-1:0]  node_addr_q;
  logic [tcam_pkg::ADDR_W-1:0]  bcast_addr_q;
  logic [tcam_pkg::ADDR_W-1:0]  header_bytes_q;
  logic [tcam_pkg::QLIM_W-1:0]  queue_limit_q;
  logic [tcam_pkg::TICKS_W-1:0] listen_window_q;
  logic [tcam_pkg::TICKS_W-1:0] listen_base_q;
  logic [tcam_pkg::TICKS_W-1:0] tx_window_q;

  // Control state
  tcam_pkg::ctrl_state_e         state_q, state_d;
  tcam_pkg::phase_e              phase_q, phase_d;
  logic [tcam_pkg::LISTEN_W-1:0] listen_left_q, listen_left_d;
  logic [tcam_pkg::TICKS_W-1:0]  window_left_q, window_left_d;
  logic                          tx_open_q, tx_open_d;
  logic [tcam_pkg::QDEPTH_W-1:0] head_q, head_d;
  logic [tcam_pkg::QDEPTH_W-1:0] tail_q, tail_d;
  logic [tcam_pkg::FILL_W-1:0]   fill_q, fill_d;

  logic                          send;
  tcam_pkg::drop_e               drop;
  logic                          do_listen;
  logic                          full;
  logic                          mine;
  logic                          open_trig;
  logic [tcam_pkg::FILL_W-1:0]   cap;
  logic [2*tcam_pkg::TICKS_W-1:0] prod;
  logic [tcam_pkg::LISTEN_W-1:0] backoff;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q     <= tcam_pkg::ADDR_W'(1);
      bcast_addr_q    <= tcam_pkg::ADDR_W'(255);
      header_bytes_q  <= '0;
      queue_limit_q   <= '0;
      listen_window_q <= '0;
      listen_base_q   <= '0;
      tx_window_q     <= tcam_pkg::TICKS_W'(1);
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        tcam_pkg::REG_NODE_ADDR:     node_addr_q     <= cfg_i.data[tcam_pkg::ADDR_W-1:0];
        tcam_pkg::REG_BCAST_ADDR:    bcast_addr_q    <= cfg_i.data[tcam_pkg::ADDR_W-1:0];
        tcam_pkg::REG_HEADER_BYTES:  header_bytes_q  <= cfg_i.data[tcam_pkg::ADDR_W-1:0];
        tcam_pkg::REG_QUEUE_LIMIT:   queue_limit_q   <= cfg_i.data[tcam_pkg::QLIM_W-1:0];
        tcam_pkg::REG_LISTEN_WINDOW: listen_window_q <= cfg_i.data;
        tcam_pkg::REG_LISTEN_BASE:   listen_base_q   <= cfg_i.data;
        tcam_pkg::REG_TX_WINDOW:     tx_window_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Backoff length, capacity and destination match
  always_comb begin
    prod    = (2*tcam_pkg::TICKS_W)'(listen_window_q) * (2*tcam_pkg::TICKS_W)'(item_i.random_draw);
    backoff = tcam_pkg::LISTEN_W'(listen_base_q)
            + tcam_pkg::LISTEN_W'(prod[2*tcam_pkg::TICKS_W-1:tcam_pkg::TICKS_W]);
    cap = (queue_limit_q == '0 || 32'(queue_limit_q) > tcam_pkg::QUEUE_DEPTH)
        ? tcam_pkg::FILL_W'(tcam_pkg::QUEUE_DEPTH) : tcam_pkg::FILL_W'(queue_limit_q);
    full      = (fill_q >= cap);
    mine      = (item_i.rx_dest_addr == node_addr_q) || (item_i.rx_dest_addr == bcast_addr_q);
    open_trig = !item_i.rx_error && mine && item_i.rx_is_trigger && !tx_open_q;
  end

  // Process one event
  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    listen_left_d = listen_left_q;
    window_left_d = window_left_q;
    tx_open_d     = tx_open_q;
    head_d        = head_q;
    tail_d        = tail_q;
    fill_d        = fill_q;
    send          = 1'b0;
    drop          = tcam_pkg::DROP_NONE;
    do_listen     = 1'b0;
    ram_wr_o      = '0;
    if (acc_i) begin
      case (item_i.mode)
        tcam_pkg::MODE_TICK: begin
          // Listen countdown first, then the window countdown
          if (phase_q == tcam_pkg::PH_RUNNING) begin
            if (listen_left_q <= tcam_pkg::LISTEN_W'(1)) begin
              listen_left_d = '0;
              phase_d       = tcam_pkg::PH_EXPIRED;
              if (state_q == tcam_pkg::ST_LISTEN && tx_open_q) begin
                if (fill_q == '0) begin
                  phase_d = tcam_pkg::PH_STOPPED;
                  state_d = tcam_pkg::ST_IDLE;
                end else begin
                  send    = 1'b1;
                  head_d  = tcam_pkg::next_ptr(head_q);
                  fill_d  = fill_q - tcam_pkg::FILL_W'(1);
                  state_d = tcam_pkg::ST_TX;
                end
              end
            end else begin
              listen_left_d = listen_left_q - tcam_pkg::LISTEN_W'(1);
            end
          end
          if (tx_open_q) begin
            if (window_left_q <= tcam_pkg::TICKS_W'(1)) begin
              window_left_d = '0;
              tx_open_d     = 1'b0;
            end else begin
              window_left_d = window_left_q - tcam_pkg::TICKS_W'(1);
            end
          end
        end
        tcam_pkg::MODE_SUBMIT: begin
          if (full) begin
            drop = tcam_pkg::DROP_FULL;
          end else begin
            ram_wr_o.we   = 1'b1;
            ram_wr_o.addr = tail_q;
            ram_wr_o.data = {item_i.pkt_handle, item_i.pkt_length};
            tail_d        = tcam_pkg::next_ptr(tail_q);
            fill_d        = fill_q + tcam_pkg::FILL_W'(1);
            do_listen     = (state_q == tcam_pkg::ST_IDLE);
          end
        end
        tcam_pkg::MODE_RX_START: begin
          if (state_q == tcam_pkg::ST_IDLE) begin
            state_d = tcam_pkg::ST_RX_IDLE;
          end else if (state_q == tcam_pkg::ST_LISTEN) begin
            state_d = tcam_pkg::ST_RX_LISTEN;
          end
        end
        tcam_pkg::MODE_RX_END: begin
          if (item_i.rx_error) begin
            drop = tcam_pkg::DROP_CORRUPT;
          end
          if (open_trig) begin
            tx_open_d     = 1'b1;
            window_left_d = tx_window_q;
          end
          if (state_q == tcam_pkg::ST_RX_IDLE || state_q == tcam_pkg::ST_RX_LISTEN) begin
            if (open_trig && fill_q != '0) begin
              do_listen = 1'b1;
            end else if (state_q == tcam_pkg::ST_RX_IDLE) begin
              // Foreign frame from rx idle: go idle, relisten if allowed
              phase_d   = tcam_pkg::PH_STOPPED;
              state_d   = tcam_pkg::ST_IDLE;
              do_listen = tx_open_d && fill_q != '0;
            end else if (phase_q == tcam_pkg::PH_RUNNING) begin
              state_d = tcam_pkg::ST_LISTEN;
            end else begin
              do_listen = 1'b1;
            end
          end
        end
        tcam_pkg::MODE_TX_END: begin
          if (state_q == tcam_pkg::ST_TX) begin
            phase_d   = tcam_pkg::PH_STOPPED;
            state_d   = tcam_pkg::ST_IDLE;
            do_listen = tx_open_q && fill_q != '0;
          end
        end
        default: ;
      endcase
      // Start a fresh backoff
      if (do_listen) begin
        state_d       = tcam_pkg::ST_LISTEN;
        listen_left_d = backoff;
        phase_d       = tcam_pkg::PH_RUNNING;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tcam_pkg::ST_IDLE;
      phase_q       <= tcam_pkg::PH_STOPPED;
      listen_left_q <= '0;
      window_left_q <= '0;
      tx_open_q     <= 1'b0;
      head_q        <= '0;
      tail_q        <= '0;
      fill_q        <= '0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      listen_left_q <= listen_left_d;
      window_left_q <= window_left_d;
      tx_open_q     <= tx_open_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      fill_q        <= fill_d;
    end
  end

  // Result control fields, taken after the event
  always_comb begin
    info_o.tx_start     = send;
    info_o.drop_code    = drop;
    info_o.node_state   = tcam_pkg::state_code(state_d);
    info_o.tx_permitted = tx_open_d;
    info_o.queue_count  = tcam_pkg::COUNT_W'(fill_d);
  end

  assign ram_raddr_o = head_q;
  assign hdr_o       = header_bytes_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= tcam_pkg::FILL_W'(tcam_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");
  a_send_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send |-> (tx_open_q && fill_q != '0 && state_q == tcam_pkg::ST_LISTEN))
    else $error("transmission started without permission or packet");
  a_tx_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcam_pkg::ST_TX) |-> (phase_q == tcam_pkg::PH_EXPIRED))
    else $error("backoff running while transmitting");
  a_expired_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tcam_pkg::PH_EXPIRED) |-> (listen_left_q == '0))
    else $error("expired backoff with ticks left");

endmodule

// ----- rtl/tcam_resp.sv -----
// Result pipeline: a stage that waits for the queue RAM read data, then an
// output register toward the result channel. Uses tcam_pkg.
module tcam_resp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  tcam_pkg::rsp_info_t          info_i,
  input  logic [tcam_pkg::ENTRY_W-1:0] rdata_i,
  input  logic [tcam_pkg::ADDR_W-1:0]  hdr_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tcam_pkg::out_item_t          out_o
);

  logic                s1_v_q, s1_v_d;
  tcam_pkg::rsp_info_t s1_q;
  logic                out_v_q, out_v_d;
  tcam_pkg::out_item_t out_q, out_d;
  logic                s1_adv;

  // Stage 1 moves on whenever the output register is free or being taken
  assign s1_adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign s1_v_d     = acc_i || (s1_v_q && !s1_adv);
  assign out_v_d    = s1_adv || (out_v_q && !out_ready_i);

  // Merge control fields with the descriptor read from the queue
  always_comb begin
    out_d.tx_start     = s1_q.tx_start;
    out_d.tx_handle    = '0;
    out_d.tx_length    = '0;
    out_d.drop_code    = s1_q.drop_code;
    out_d.node_state   = s1_q.node_state;
    out_d.tx_permitted = s1_q.tx_permitted;
    out_d.queue_count  = s1_q.queue_count;
    if (s1_q.tx_start) begin
      out_d.tx_handle = rdata_i[tcam_pkg::ENTRY_W-1:tcam_pkg::LEN_W];
      out_d.tx_length = tcam_pkg::TXLEN_W'(rdata_i[tcam_pkg::LEN_W-1:0])
                      + tcam_pkg::TXLEN_W'(hdr_i);
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= info_i;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of triggered_csma_aloha_mac_top: streams MAC events with random
// idling on both channels and compares each result with a behavioral model of the node.
// Depends on tcam_pkg, the tcam_if channel interfaces and the top level RTL.
module testbench;
  import tcam_pkg::*;

  // One full register setting of the MAC
  typedef struct {
    logic [ADDR_W-1:0]  node_addr;
    logic [ADDR_W-1:0]  bcast_addr;
    logic [7:0]         header_bytes;
    logic [QLIM_W-1:0]  queue_limit;
    logic [TICKS_W-1:0] listen_window;
    logic [TICKS_W-1:0] listen_base;
    logic [TICKS_W-1:0] tx_window;
  } mac_settings_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tcam_in_if  ev_if ();
  tcam_out_if res_if ();
  tcam_cfg_if cfg_if ();

  triggered_csma_aloha_mac_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and expected results
  in_item_t    mac_events[$];
  out_item_t   mac_reports[$];
  in_item_t    ev_held;
  int unsigned events_issued = 0;
  int unsigned events_taken  = 0;
  int unsigned error_count   = 0;
  bit          steady        = 1'b0;

  // Model state of the node
  mac_settings_t         mac_cfg;
  logic [NSTATE_W-1:0]   mac_state;
  logic [LISTEN_W-1:0]   backoff_left;
  phase_e                backoff_phase;
  logic [TICKS_W-1:0]    window_left;
  logic                  window_open;
  logic [ENTRY_W-1:0]    pkt_slots[QUEUE_DEPTH];
  logic [QDEPTH_W-1:0]   q_head;
  logic [QDEPTH_W-1:0]   q_tail;
  logic [FILL_W-1:0]     q_fill;

  // Random idle decision shared by both channels
  function automatic bit hold_off();
    return !steady && ($urandom_range(99) < 6);
  endfunction

  task automatic report_error(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic mac_reset();
    mac_cfg       = '{8'd1, 8'd255, 8'd0, 5'd0, 16'd0, 16'd0, 16'd1};
    mac_state     = NS_IDLE;
    backoff_left  = '0;
    backoff_phase = PH_STOPPED;
    window_left   = '0;
    window_open   = 1'b0;
    q_head        = '0;
    q_tail        = '0;
    q_fill        = '0;
    foreach (pkt_slots[i]) pkt_slots[i] = '0;
  endtask

  // Start a listen backoff of base plus the truncated product of listen window and draw
  task automatic begin_backoff(input logic [DRAW_W-1:0] draw);
    logic [31:0] span;
    span          = mac_cfg.listen_window * draw;
    mac_state     = NS_LISTEN;
    backoff_left  = LISTEN_W'(mac_cfg.listen_base) + LISTEN_W'(span[31:16]);
    backoff_phase = PH_RUNNING;
  endtask

  task automatic enter_idle(input logic [DRAW_W-1:0] draw);
    backoff_phase = PH_STOPPED;
    mac_state     = NS_IDLE;
    if (window_open && q_fill > 0) begin_backoff(draw);
  endtask

  // Send the queue head if the window is open; with an empty queue go idle instead
  task automatic send_head(inout out_item_t r);
    logic [ENTRY_W-1:0] entry;
    if (!window_open) return;
    if (q_fill == 0) begin
      enter_idle('0);
      return;
    end
    entry       = pkt_slots[q_head];
    q_head      = q_head + 1'b1;
    q_fill      = q_fill - 1'b1;
    mac_state   = NS_TX;
    r.tx_start  = 1'b1;
    r.tx_handle = entry[ENTRY_W-1:LEN_W];
    r.tx_length = TXLEN_W'(entry[LEN_W-1:0]) + TXLEN_W'(mac_cfg.header_bytes);
  endtask

  task automatic foreign_frame_end(input logic [NSTATE_W-1:0] prev,
                                   input logic [DRAW_W-1:0] draw);
    if (prev == NS_RX_IDLE) begin
      enter_idle(draw);
    end else if (backoff_phase == PH_RUNNING) begin
      mac_state = NS_LISTEN;
    end else begin
      begin_backoff(draw);
    end
  endtask

  task automatic open_window();
    window_open = 1'b1;
    window_left = mac_cfg.tx_window;
  endtask

  // Advance the node model by one event and queue the result it yields
  task automatic mac_step(input in_item_t ev);
    out_item_t           r;
    logic [NSTATE_W-1:0] prev;
    logic                valid_trigger;
    int unsigned         cap;
    r = '0;
    r.drop_code = DROP_NONE;
    valid_trigger = !ev.rx_error && ev.rx_is_trigger && !window_open &&
                    (ev.rx_dest_addr == mac_cfg.node_addr ||
                     ev.rx_dest_addr == mac_cfg.bcast_addr);
    case (ev.mode)
      MODE_TICK: begin
        // Listen countdown first, then the window countdown
        if (backoff_phase == PH_RUNNING) begin
          if (backoff_left <= 1) begin
            backoff_left  = '0;
            backoff_phase = PH_EXPIRED;
            if (mac_state == NS_LISTEN) send_head(r);
          end else begin
            backoff_left = backoff_left - 1'b1;
          end
        end
        if (window_open) begin
          if (window_left <= 1) begin
            window_left = '0;
            window_open = 1'b0;
          end else begin
            window_left = window_left - 1'b1;
          end
        end
      end
      MODE_SUBMIT: begin
        cap = (mac_cfg.queue_limit == 0 || mac_cfg.queue_limit > QUEUE_DEPTH) ?
              QUEUE_DEPTH : mac_cfg.queue_limit;
        if (q_fill >= cap) begin
          r.drop_code = DROP_FULL;
        end else begin
          pkt_slots[q_tail] = {ev.pkt_handle, ev.pkt_length};
          q_tail = q_tail + 1'b1;
          q_fill = q_fill + 1'b1;
          if (mac_state == NS_IDLE) begin_backoff(ev.random_draw);
        end
      end
      MODE_RX_START: begin
        if (mac_state == NS_IDLE) mac_state = NS_RX_IDLE;
        else if (mac_state == NS_LISTEN) mac_state = NS_RX_LISTEN;
      end
      MODE_RX_END: begin
        prev = mac_state;
        if (ev.rx_error) r.drop_code = DROP_CORRUPT;
        if (prev != NS_RX_IDLE && prev != NS_RX_LISTEN) begin
          if (valid_trigger) open_window();
        end else if (valid_trigger && q_fill > 0) begin
          open_window();
          begin_backoff(ev.random_draw);
        end else begin
          if (valid_trigger) open_window();
          foreign_frame_end(prev, ev.random_draw);
        end
      end
      MODE_TX_END: begin
        if (mac_state == NS_TX) enter_idle(ev.random_draw);
      end
      default: ;
    endcase
    r.node_state   = mac_state;
    r.tx_permitted = window_open;
    r.queue_count  = q_fill;
    mac_reports.push_back(r);
  endtask

  // Event driver: hold each transfer until accepted, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_if.valid <= 1'b0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        mac_step(ev_held);
        events_taken++;
      end
      if (!ev_if.valid || ev_if.ready) begin
        if (mac_events.size() > 0 && !hold_off()) begin
          ev_held = mac_events.pop_front();
          ev_if.valid         <= 1'b1;
          ev_if.mode          <= ev_held.mode;
          ev_if.pkt_handle    <= ev_held.pkt_handle;
          ev_if.pkt_length    <= ev_held.pkt_length;
          ev_if.rx_error      <= ev_held.rx_error;
          ev_if.rx_dest_addr  <= ev_held.rx_dest_addr;
          ev_if.rx_is_trigger <= ev_held.rx_is_trigger;
          ev_if.random_draw   <= ev_held.random_draw;
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) check_result();
      res_if.ready <= !hold_off();
    end
  end

  task automatic check_result();
    out_item_t want;
    if (mac_reports.size() == 0) begin
      report_error("result with no event waiting for it");
      return;
    end
    want = mac_reports.pop_front();
    check_field("tx_start", res_if.tx_start, want.tx_start);
    check_field("tx_handle", res_if.tx_handle, want.tx_handle);
    check_field("tx_length", res_if.tx_length, want.tx_length);
    check_field("drop_code", res_if.drop_code, want.drop_code);
    check_field("node_state", res_if.node_state, want.node_state);
    check_field("tx_permitted", res_if.tx_permitted, want.tx_permitted);
    check_field("queue_count", res_if.queue_count, want.queue_count);
  endtask

  task automatic push_event(input mode_e m, input logic [HANDLE_W-1:0] handle,
                            input logic [LEN_W-1:0] len, input logic err,
                            input logic [ADDR_W-1:0] dest, input logic trig,
                            input logic [DRAW_W-1:0] draw);
    in_item_t ev;
    ev = '{m, handle, len, err, dest, trig, draw};
    mac_events.push_back(ev);
    events_issued++;
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(input cfg_reg_e idx, input logic [CDATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_NODE_ADDR:     mac_cfg.node_addr     = val[ADDR_W-1:0];
      REG_BCAST_ADDR:    mac_cfg.bcast_addr    = val[ADDR_W-1:0];
      REG_HEADER_BYTES:  mac_cfg.header_bytes  = val[7:0];
      REG_QUEUE_LIMIT:   mac_cfg.queue_limit   = val[QLIM_W-1:0];
      REG_LISTEN_WINDOW: mac_cfg.listen_window = val;
      REG_LISTEN_BASE:   mac_cfg.listen_base   = val;
      REG_TX_WINDOW:     mac_cfg.tx_window     = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input mac_settings_t s);
    write_reg(REG_NODE_ADDR, CDATA_W'(s.node_addr));
    write_reg(REG_BCAST_ADDR, CDATA_W'(s.bcast_addr));
    write_reg(REG_HEADER_BYTES, CDATA_W'(s.header_bytes));
    write_reg(REG_QUEUE_LIMIT, CDATA_W'(s.queue_limit));
    write_reg(REG_LISTEN_WINDOW, s.listen_window);
    write_reg(REG_LISTEN_BASE, s.listen_base);
    write_reg(REG_TX_WINDOW, s.tx_window);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every event is accepted and every result checked, then settle
  task automatic drain();
    while (events_taken != events_issued || mac_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Walk the backoff, window, queue-full and frame-end corners by hand
  task automatic directed_events();
    push_event(MODE_TICK, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    // Corrupted frame and trigger while not receiving
    push_event(MODE_RX_END, 16'h0000, 12'h000, 1'b1, 8'h5A, 1'b1, 16'h0000);
    push_event(MODE_RX_END, 16'h0000, 12'h000, 1'b0, 8'h5A, 1'b1, 16'h0000);
    push_event(MODE_TX_END, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    // Fill the queue past its limit, zero backoff
    push_event(MODE_SUBMIT, 16'hFFFF, 12'hFFF, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_SUBMIT, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'hFFFF);
    push_event(MODE_SUBMIT, 16'h1234, 12'h5A5, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TX_END, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0001);
    // Foreign frame while listening, backoff still running
    push_event(MODE_RX_START, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_RX_START, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_RX_END, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TX_END, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    // Expiry with the window closed, then a broadcast trigger
    push_event(MODE_SUBMIT, 16'hABCD, 12'h123, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_RX_START, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_RX_END, 16'h0000, 12'h000, 1'b0, 8'hFF, 1'b1, 16'h0000);
    // Trigger with the window already open
    push_event(MODE_RX_START, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_RX_END, 16'h0000, 12'h000, 1'b0, 8'h5A, 1'b1, 16'h0000);
    push_event(MODE_TICK, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TX_END, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    // Backoff expiry while receiving, then a foreign frame restarts it
    push_event(MODE_SUBMIT, 16'h5555, 12'hAAA, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_RX_START, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_RX_END, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b1, 16'h8000);
    // Corrupted frame ending a reception while listening
    push_event(MODE_RX_START, 16'h0000, 12'h000, 1'b0, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_RX_END, 16'h0000, 12'h000, 1'b1, 8'h5A, 1'b1, 16'h0000);
  endtask

  function automatic logic [ADDR_W-1:0] pick_dest(input mac_settings_t s);
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return s.node_addr;
    if (r < 8) return s.bcast_addr;
    return ADDR_W'($urandom_range(255));
  endfunction

  // Mostly well-formed traffic: ticks, submits, complete frames, tx ends
  task automatic random_events(input int unsigned count, input mac_settings_t s);
    int unsigned made;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_event(MODE_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        made += 1;
      end else if (pick < 55) begin
        push_event(MODE_SUBMIT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        made += 1;
      end else if (pick < 80) begin
        push_event(MODE_RX_START, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
        push_event(MODE_RX_END, $urandom, $urandom, $urandom_range(9) == 0, pick_dest(s),
                   $urandom_range(9) < 7, $urandom);
        made += 2;
      end else if (pick < 92) begin
        push_event(MODE_TX_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        made += 1;
      end else begin
        // Stray half of a frame
        push_event(pick[0] ? MODE_RX_START : MODE_RX_END, $urandom, $urandom, $urandom,
                   pick_dest(s), $urandom, $urandom);
        made += 1;
      end
    end
  endtask

  task automatic run_phase(input mac_settings_t s, input int unsigned count, input bit calm);
    apply_settings(s);
    steady = calm;
    random_events(count, s);
    drain();
    steady = 1'b0;
  endtask

  initial begin
    mac_settings_t s;
    rst_ni              = 1'b0;
    ev_if.valid         = 1'b0;
    ev_if.mode          = '0;
    ev_if.pkt_handle    = '0;
    ev_if.pkt_length    = '0;
    ev_if.rx_error      = 1'b0;
    ev_if.rx_dest_addr  = '0;
    ev_if.rx_is_trigger = 1'b0;
    ev_if.random_draw   = '0;
    res_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    mac_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners with a two-entry queue and a short window
    s = '{8'h5A, 8'hFF, 8'hFF, 5'd2, 16'hFFFF, 16'd0, 16'd3};
    apply_settings(s);
    directed_events();
    drain();

    // Low extremes, high extremes, then mid-range settings
    s = '{8'd1, 8'd255, 8'd0, 5'd0, 16'd0, 16'd0, 16'd1};
    run_phase(s, 360, 1'b0);
    s = '{8'd255, 8'd0, 8'd255, 5'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    run_phase(s, 150, 1'b0);
    s = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
          5'($urandom_range(16, 1)), 16'd8, 16'd2, 16'd40};
    run_phase(s, 360, 1'b0);
    s = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
          5'd1, 16'd3, 16'd0, 16'd20};
    run_phase(s, 360, 1'b0);
    s = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
          5'd4, 16'd0, 16'd1, 16'd100};
    run_phase(s, 360, 1'b1);
    s = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
          5'd0, 16'd20, 16'd0, 16'd300};
    run_phase(s, 360, 1'b0);

    if (error_count == 0) begin
      $display("** triggered_csma_aloha_mac_top: PASSED **");
    end else begin
      $display("** triggered_csma_aloha_mac_top: FAILED **");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #5000000;
    $display("** triggered_csma_aloha_mac_top: FAILED **");
    $finish;
  end

endmodule
